// ===== rtl/core/gdr_pkg.sv =====
// Package: shared types and constants for the grid diffusion relaxation core.
`timescale 1ns / 1ps
`default_nettype none
package gdr_pkg;
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_SOLVE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_COEF  = 2'd0,
		REG_RECIP = 2'd1,
		REG_SWEEP = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [31:0] COEF_RESET  = 32'd0;
	localparam logic [16:0] RECIP_RESET = 17'd65536;
	localparam logic [7:0]  SWEEP_RESET = 8'd20;

	// Intermediate saturation limit 2^61.
	localparam int INTER_BITS = 62;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_N,
		ST_RD_S,
		ST_RD_W,
		ST_RD_E,
		ST_MUL_A,
		ST_MUL_R,
		ST_WRITE
	} state_t;

	// Sequencer to datapath control bundle.
	typedef struct packed {
		logic load_sum;
		logic load_q;
		logic load_v;
	} dp_ctl_t;

	// floor(x*y/2^16) saturated to signed 62 bits. x signed 62 bits, y unsigned 32.
	function automatic logic signed [INTER_BITS-1:0] mul_shift_sat(
		input logic signed [INTER_BITS-1:0] x, input logic [31:0] y);
		logic signed [94:0] p;
		logic signed [78:0] sh;
		logic signed [INTER_BITS-1:0] r;
		p = x * $signed({1'b0, y});
		sh = 79'(p >>> 16);
		if (sh > 79'sd2305843009213693951)
			r = {1'b0, {(INTER_BITS-1){1'b1}}};
		else if (sh < -79'sd2305843009213693952)
			r = {1'b1, {(INTER_BITS-1){1'b0}}};
		else
			r = sh[INTER_BITS-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/gdr_if.sv =====
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface gdr_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [11:0] cell_address;
	logic signed [31:0] source_value;
	logic signed [31:0] start_value;
	modport source(output valid, command, cell_address, source_value, start_value, input ready);
	modport sink(input valid, command, cell_address, source_value, start_value, output ready);
endinterface

interface gdr_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic signed [31:0] cell_value;
	modport source(output valid, result_kind, cell_value, input ready);
	modport sink(input valid, result_kind, cell_value, output ready);
endinterface

interface gdr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gdr_grid_mem.sv =====
// Grid memory: one synchronous port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gdr_grid_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/gdr_datapath.sv =====
// Datapath: neighbor accumulation, two scaled multiplies, cell saturation.
`timescale 1ns / 1ps
`default_nettype none
module gdr_datapath #(
	parameter int CELL_BITS = 32
) (
	input  wire logic                        clk,
	input  wire gdr_pkg::dp_ctl_t            ctl,
	input  wire logic                        clr_sum,
	input  wire logic signed [CELL_BITS-1:0] nbr,
	input  wire logic signed [CELL_BITS-1:0] src,
	input  wire logic [31:0]                 coef,
	input  wire logic [16:0]                 recip,
	output logic signed [CELL_BITS-1:0]      result
);
	localparam int IB = gdr_pkg::INTER_BITS;
	localparam int SB = CELL_BITS + 2;
	logic signed [SB-1:0] sum_q;
	logic signed [IB-1:0] t_q;
	logic signed [IB-1:0] q, v, t_sum;
	logic signed [IB:0] t_raw;
	logic signed [IB-1:0] hi_lim, lo_lim;

	assign hi_lim = IB'((64'sd1 <<< (CELL_BITS-1)) - 64'sd1);
	assign lo_lim = -hi_lim - IB'(1);
	assign q = gdr_pkg::mul_shift_sat(IB'(sum_q), coef);
	assign t_raw = (IB+1)'(q) + (IB+1)'(src);
	assign t_sum = (t_raw[IB] != t_raw[IB-1]) ?
		(t_raw[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}}) : t_raw[IB-1:0];
	assign v = gdr_pkg::mul_shift_sat(t_q, {15'd0, recip});

	always_ff @(posedge clk) begin
		if (clr_sum)
			sum_q <= SB'(nbr);
		else if (ctl.load_sum)
			sum_q <= sum_q + SB'(nbr);
		if (ctl.load_q)
			t_q <= t_sum;
		if (ctl.load_v)
			result <= (v > hi_lim) ? CELL_BITS'(hi_lim) :
				(v < lo_lim) ? CELL_BITS'(lo_lim) : CELL_BITS'(v);
	end
endmodule
`default_nettype wire

// ===== rtl/core/grid_diffusion_relaxation_core.sv =====
// Top level: command decode, solve sequencer, grid memories and result register.
// A write in range stores both grid memories at acceptance. A read result is taken from the
// value memory's registered read data into the output register; no new command is accepted
// while a read is pending or the result waits. A solve returns the done result after its
// last write-back: each interior cell needs four neighbor reads on the single value-memory
// port, two multiply steps, a result load and a write-back, in sweep order so every update
// sees the latest neighbors. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module grid_diffusion_relaxation_core #(
	parameter int GRID_INTERIOR = 62,
	parameter int CELL_BITS     = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gdr_cmd_if.sink   cmd,
	gdr_res_if.source res,
	gdr_cfg_if.sink   cfg
);
	localparam int SIDE  = GRID_INTERIOR + 2;
	localparam int CELLS = SIDE * SIDE;
	localparam int AW    = 12;
	localparam int IW    = $clog2(GRID_INTERIOR + 2);

	logic [31:0] coef_q;
	logic [16:0] recip_q;
	logic [7:0]  sweep_q;

	gdr_pkg::state_t state_q, state_d;
	logic [IW-1:0] i_q, j_q;
	logic [7:0]    k_q;
	logic          rd_pend_s1, rd_oob_s1;
	logic          done_pend_q;

	logic [AW-1:0] val_addr, src_addr, c_addr;
	logic          val_we, src_we;
	logic signed [CELL_BITS-1:0] val_wd, src_wd, val_rd, src_rd, upd;
	gdr_pkg::dp_ctl_t ctl;
	logic clr_sum, accept, idle, out_free, last_cell;
	logic signed [31:0] wsrc_in, wval_in;

	// Write-back is issued in the cycle after the result register loads.
	logic wb_s1;
	logic [AW-1:0] wb_addr_s1;
	logic more_s1;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= gdr_pkg::COEF_RESET;
			recip_q <= gdr_pkg::RECIP_RESET;
			sweep_q <= gdr_pkg::SWEEP_RESET;
		end else if (cfg.valid) begin
			unique case (gdr_pkg::reg_idx_t'(cfg.index))
				gdr_pkg::REG_COEF:  coef_q  <= cfg.data;
				gdr_pkg::REG_RECIP: recip_q <= cfg.data[16:0];
				gdr_pkg::REG_SWEEP: sweep_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	assign out_free = !res.valid || res.ready;
	assign idle = (state_q == gdr_pkg::ST_IDLE) && !done_pend_q;
	assign cmd.ready = idle && !rd_pend_s1 && out_free;
	assign accept = cmd.valid && cmd.ready;

	assign c_addr = AW'(32'(i_q) + SIDE * 32'(j_q));
	assign last_cell = (i_q == IW'(GRID_INTERIOR)) && (j_q == IW'(GRID_INTERIOR));

	function automatic logic signed [CELL_BITS-1:0] sat_in(input logic signed [31:0] x);
		logic signed [63:0] hi, lo;
		hi = (64'sd1 <<< (CELL_BITS-1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (64'(x) > hi) return CELL_BITS'(hi);
		if (64'(x) < lo) return CELL_BITS'(lo);
		return CELL_BITS'(x);
	endfunction

	assign wsrc_in = cmd.source_value;
	assign wval_in = cmd.start_value;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		clr_sum = 1'b0;
		val_addr = cmd.cell_address;
		val_we = 1'b0;
		val_wd = sat_in(wval_in);
		src_addr = cmd.cell_address;
		src_we = 1'b0;
		src_wd = sat_in(wsrc_in);
		unique case (state_q)
			gdr_pkg::ST_IDLE: begin
				if (wb_s1 && more_s1)
					state_d = gdr_pkg::ST_RD_N;
				if (accept && gdr_pkg::cmd_t'(cmd.command) == gdr_pkg::CMD_WRITE &&
					32'(cmd.cell_address) < CELLS) begin
					val_we = 1'b1;
					src_we = 1'b1;
				end
				if (accept && gdr_pkg::cmd_t'(cmd.command) == gdr_pkg::CMD_SOLVE &&
					sweep_q != 8'd0) begin
					state_d = gdr_pkg::ST_RD_N;
				end
			end
			gdr_pkg::ST_RD_N: begin
				val_addr = c_addr - AW'(1);
				state_d = gdr_pkg::ST_RD_S;
			end
			gdr_pkg::ST_RD_S: begin
				val_addr = c_addr + AW'(1);
				clr_sum = 1'b1;
				state_d = gdr_pkg::ST_RD_W;
			end
			gdr_pkg::ST_RD_W: begin
				val_addr = c_addr - AW'(SIDE);
				ctl.load_sum = 1'b1;
				state_d = gdr_pkg::ST_RD_E;
			end
			gdr_pkg::ST_RD_E: begin
				val_addr = c_addr + AW'(SIDE);
				src_addr = c_addr;
				ctl.load_sum = 1'b1;
				state_d = gdr_pkg::ST_MUL_A;
			end
			gdr_pkg::ST_MUL_A: begin
				src_addr = c_addr;
				ctl.load_sum = 1'b1;
				state_d = gdr_pkg::ST_MUL_R;
			end
			gdr_pkg::ST_MUL_R: begin
				ctl.load_q = 1'b1;
				state_d = gdr_pkg::ST_WRITE;
			end
			gdr_pkg::ST_WRITE: begin
				ctl.load_v = 1'b1;
				state_d = gdr_pkg::ST_IDLE;
			end
			default: state_d = gdr_pkg::ST_IDLE;
		endcase
		if (wb_s1) begin
			val_addr = wb_addr_s1;
			val_we = 1'b1;
			val_wd = upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdr_pkg::ST_IDLE;
			i_q <= IW'(1);
			j_q <= IW'(1);
			k_q <= '0;
			wb_s1 <= 1'b0;
			more_s1 <= 1'b0;
			done_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wb_s1 <= (state_q == gdr_pkg::ST_WRITE);
			if (accept && gdr_pkg::cmd_t'(cmd.command) == gdr_pkg::CMD_SOLVE) begin
				done_pend_q <= 1'b1;
				i_q <= IW'(1);
				j_q <= IW'(1);
				k_q <= '0;
			end else begin
				if (done_pend_q && state_q == gdr_pkg::ST_IDLE && !wb_s1 && out_free)
					done_pend_q <= 1'b0;
				if (state_q == gdr_pkg::ST_WRITE) begin
					more_s1 <= !(last_cell && k_q == sweep_q - 8'd1);
					if (j_q == IW'(GRID_INTERIOR)) begin
						j_q <= IW'(1);
						if (i_q == IW'(GRID_INTERIOR)) begin
							i_q <= IW'(1);
							k_q <= k_q + 8'd1;
						end else
							i_q <= i_q + IW'(1);
					end else
						j_q <= j_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gdr_pkg::ST_WRITE)
			wb_addr_s1 <= c_addr;
		rd_oob_s1 <= !(32'(cmd.cell_address) < CELLS);
	end

	gdr_grid_mem #(.DEPTH(CELLS), .AW(AW), .DW(CELL_BITS)) u_val (
		.clk(clk), .we(val_we), .addr(val_addr), .wdata(val_wd), .rdata(val_rd));
	gdr_grid_mem #(.DEPTH(CELLS), .AW(AW), .DW(CELL_BITS)) u_src (
		.clk(clk), .we(src_we), .addr(src_addr), .wdata(src_wd), .rdata(src_rd));

	gdr_datapath #(.CELL_BITS(CELL_BITS)) u_dp (
		.clk(clk), .ctl(ctl), .clr_sum(clr_sum), .nbr(val_rd), .src(src_rd),
		.coef(coef_q), .recip(recip_q), .result(upd));

	logic signed [31:0] rd_sat;
	always_comb begin
		if (64'(val_rd) > 64'sd2147483647) rd_sat = 32'sh7FFFFFFF;
		else if (64'(val_rd) < -64'sd2147483648) rd_sat = 32'sh80000000;
		else rd_sat = 32'(val_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= accept && gdr_pkg::cmd_t'(cmd.command) == gdr_pkg::CMD_READ;
			if (rd_pend_s1) begin
				res.valid <= 1'b1;
				res.result_kind <= gdr_pkg::KIND_READ;
				res.cell_value <= rd_oob_s1 ? 32'sd0 : rd_sat;
			end else if (done_pend_q && state_q == gdr_pkg::ST_IDLE && !wb_s1 && out_free) begin
				res.valid <= 1'b1;
				res.result_kind <= gdr_pkg::KIND_DONE;
				res.cell_value <= 32'sd0;
			end else if (res.valid && res.ready)
				res.valid <= 1'b0;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gdr_pkg::ST_IDLE) |-> !cmd.ready)
		else $error("command accepted during solve");
	a_wb_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wb_s1 |-> (32'(wb_addr_s1) < CELLS))
		else $error("write-back outside grid");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |=> (res.valid && res.result_kind == gdr_pkg::KIND_READ))
		else $error("read result missing");
endmodule
`default_nettype wire

// ===== dv/gdr_tb_if.sv =====
// Testbench channels use the command, result and configuration interfaces of the core.
`timescale 1ns / 1ps

// ===== dv/testbench.sv =====
// Testbench: random and directed grid commands checked against a Gauss-Seidel predictor.
`timescale 1ns / 1ps
module testbench;
	localparam int SIDE  = 64;
	localparam int CELLS = SIDE * SIDE;
	localparam int INNER = 62;
	localparam logic signed [127:0] LIM_HI = (128'sd1 <<< 61) - 128'sd1;
	localparam logic signed [127:0] LIM_LO = -(128'sd1 <<< 61);

	typedef struct {
		gdr_pkg::cmd_t op;
		logic [11:0] addr;
		logic signed [31:0] src;
		logic signed [31:0] init;
	} grid_op_t;

	typedef struct {
		logic        kind;
		logic signed [31:0] value;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	gdr_cmd_if cmd();
	gdr_res_if res();
	gdr_cfg_if cfg();

	grid_diffusion_relaxation_core uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res), .cfg(cfg)
	);

	grid_op_t     pending_ops[$];
	cell_result_t expected_cells[$];
	logic signed [31:0] src_grid[CELLS];
	logic signed [31:0] val_grid[CELLS];
	logic [31:0] coef = gdr_pkg::COEF_RESET;
	logic [16:0] recip = gdr_pkg::RECIP_RESET;
	logic [7:0]  sweeps = gdr_pkg::SWEEP_RESET;
	int  mismatches = 0;
	bit  failed = 1'b0;
	bit  steady = 1'b0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_cnt = 0;
	bit  cmd_took = 1'b0;
	int  solves_left = 0;

	function automatic logic signed [61:0] scale_sat(logic signed [63:0] x, logic [31:0] y);
		logic signed [127:0] p;
		p = $signed({{64{x[63]}}, x}) * $signed({96'd0, y});
		p = p >>> 16;
		if (p > LIM_HI) p = LIM_HI;
		else if (p < LIM_LO) p = LIM_LO;
		return p[61:0];
	endfunction

	function automatic logic signed [31:0] relax_cell(int c);
		logic signed [63:0] s, t;
		logic signed [61:0] v;
		s = 64'(val_grid[c-1]) + 64'(val_grid[c+1]) + 64'(val_grid[c-SIDE])
			+ 64'(val_grid[c+SIDE]);
		t = 64'(src_grid[c]) + 64'(scale_sat(s, coef));
		if (t > 64'(LIM_HI)) t = 64'(LIM_HI);
		else if (t < 64'(LIM_LO)) t = 64'(LIM_LO);
		v = scale_sat(t, {15'd0, recip});
		if (v > 62'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -62'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic predict_op(grid_op_t op);
		cell_result_t r;
		case (op.op)
			gdr_pkg::CMD_WRITE: begin
				src_grid[op.addr] = op.src;
				val_grid[op.addr] = op.init;
			end
			gdr_pkg::CMD_SOLVE: begin
				for (int k = 0; k < sweeps; k++)
					for (int i = 1; i <= INNER; i++)
						for (int j = 1; j <= INNER; j++)
							val_grid[i + SIDE*j] = relax_cell(i + SIDE*j);
				r.kind = gdr_pkg::KIND_DONE;
				r.value = '0;
				expected_cells.push_back(r);
			end
			gdr_pkg::CMD_READ: begin
				r.kind = gdr_pkg::KIND_READ;
				r.value = val_grid[op.addr];
				expected_cells.push_back(r);
			end
			default: ;
		endcase
	endtask

	// command driver
	always @(negedge clk or negedge arst_n) begin
		grid_op_t op;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.command <= gdr_pkg::CMD_NONE;
			cmd.cell_address <= '0;
			cmd.source_value <= '0;
			cmd.start_value <= '0;
		end else if (!cmd.valid || cmd_took) begin
			if (pending_ops.size() > 0 && (steady || $urandom_range(99) >= 38)) begin
				op = pending_ops.pop_front();
				cmd.command <= op.op;
				cmd.cell_address <= op.addr;
				cmd.source_value <= op.src;
				cmd.start_value <= op.init;
				cmd.valid <= 1'b1;
			end else
				cmd.valid <= 1'b0;
		end
	end

	// result ready with one long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt <= 400;
			res.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res.ready <= 1'b0;
		end else
			res.ready <= steady || $urandom_range(99) >= 38;
	end

	// monitors
	always @(posedge clk) begin
		grid_op_t op;
		cell_result_t e;
		cmd_took <= cmd.valid && cmd.ready;
		if (arst_n && cmd.valid && cmd.ready) begin
			op.op = gdr_pkg::cmd_t'(cmd.command);
			op.addr = cmd.cell_address;
			op.src = cmd.source_value;
			op.init = cmd.start_value;
			predict_op(op);
		end
		if (arst_n && cfg.valid && cfg.ready) begin
			case (gdr_pkg::reg_idx_t'(cfg.index))
				gdr_pkg::REG_COEF:  coef = cfg.data;
				gdr_pkg::REG_RECIP: recip = cfg.data[16:0];
				gdr_pkg::REG_SWEEP: sweeps = cfg.data[7:0];
				default: ;
			endcase
		end
		if (arst_n && res.valid && res.ready) begin
			if (expected_cells.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d value=%h", res.result_kind,
						res.cell_value);
			end else begin
				e = expected_cells.pop_front();
				if (res.result_kind !== e.kind || res.cell_value !== e.value) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind=%0d value=%h, got kind=%0d value=%h",
							e.kind, e.value, res.result_kind, res.cell_value);
				end
			end
		end
	end

	task automatic push_op(gdr_pkg::cmd_t c, logic [11:0] a, logic [31:0] s, logic [31:0] v);
		grid_op_t op;
		op.op = c;
		op.addr = a;
		op.src = s;
		op.init = v;
		pending_ops.push_back(op);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_ops.size() > 0 || cmd.valid || expected_cells.size() > 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(gdr_pkg::reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg.index = idx;
		cfg.data = d;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic set_regs(logic [31:0] a, logic [31:0] r, logic [31:0] n);
		drain();
		cfg_write(gdr_pkg::REG_COEF, a);
		cfg_write(gdr_pkg::REG_RECIP, r);
		cfg_write(gdr_pkg::REG_SWEEP, n);
	endtask

	function automatic logic [31:0] rand_cell();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(131072)) - 65536);
			2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	task automatic push_random(int n);
		logic [11:0] a;
		int p;
		for (int k = 0; k < n; k++) begin
			a = 12'($urandom());
			p = $urandom_range(99);
			if (p < 50) begin
				push_op(gdr_pkg::CMD_WRITE, a, rand_cell(), rand_cell());
				push_op(gdr_pkg::CMD_READ, a, $urandom(), $urandom());
				k++;
			end else if (p < 75)
				push_op(gdr_pkg::CMD_READ, a, $urandom(), $urandom());
			else if (p < 93)
				push_op(gdr_pkg::CMD_WRITE, a, rand_cell(), rand_cell());
			else if (p < 96 && solves_left > 0) begin
				push_op(gdr_pkg::CMD_SOLVE, a, $urandom(), $urandom());
				solves_left--;
			end else
				push_op(gdr_pkg::CMD_NONE, a, $urandom(), $urandom());
		end
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.index = gdr_pkg::REG_NONE;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_regs(32'h4000, 32'd32768, 32'd1);
		for (int c = 0; c < CELLS; c++)
			push_op(gdr_pkg::CMD_WRITE, 12'(c), rand_cell(), rand_cell());
		push_op(gdr_pkg::CMD_WRITE, 12'd0, 32'h80000000, 32'h7FFFFFFF);
		push_op(gdr_pkg::CMD_WRITE, 12'd4095, 32'h7FFFFFFF, 32'h80000000);
		push_op(gdr_pkg::CMD_WRITE, 12'd65, 32'h7FFFFFFF, 32'h7FFFFFFF);
		push_op(gdr_pkg::CMD_WRITE, 12'd130, 32'h80000000, 32'h80000000);
		push_op(gdr_pkg::CMD_READ, 12'd0, '0, '0);
		push_op(gdr_pkg::CMD_READ, 12'd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_op(gdr_pkg::CMD_NONE, 12'd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_op(gdr_pkg::CMD_READ, 12'd65, '0, '0);
		push_op(gdr_pkg::CMD_SOLVE, 12'd0, '0, '0);
		push_op(gdr_pkg::CMD_READ, 12'd65, '0, '0);
		push_op(gdr_pkg::CMD_READ, 12'd130, '0, '0);
		push_op(gdr_pkg::CMD_READ, 12'd0, '0, '0);
		push_op(gdr_pkg::CMD_READ, 12'd2080, '0, '0);

		// saturating coefficient, zero reciprocal, zero sweeps
		set_regs(32'hFFFFFFFF, 32'd0, 32'd0);
		push_op(gdr_pkg::CMD_SOLVE, 12'd0, '0, '0);
		push_op(gdr_pkg::CMD_READ, 12'd65, '0, '0);
		solves_left = 4;
		push_random(250);

		// max sweep setting, no solves
		set_regs(32'd0, 32'd65536, 32'd255);
		steady = 1'b1;
		solves_left = 0;
		push_random(250);
		drain();
		steady = 1'b0;

		set_regs(32'h10000, 32'd13107, 32'd2);
		@(negedge clk);
		hold_req = 1'b1;
		solves_left = 2;
		push_random(300);

		// reciprocal above one
		set_regs(32'h2000, 32'h1FFFF, 32'd1);
		solves_left = 3;
		push_random(300);

		drain();
		repeat (20) @(posedge clk);
		if (!failed && expected_cells.size() == 0)
			$display("** grid_diffusion_relaxation_core: PASSED **");
		else
			$display("** grid_diffusion_relaxation_core: FAILED **");
		$finish;
	end

	initial begin
		#40ms;
		$display("** grid_diffusion_relaxation_core: FAILED **");
		$finish;
	end
endmodule
